@@ hdl/c2tet_pkg.sv @@
package c2tet_pkg;

   // Field widths
   localparam int CUBE_W        = 10;
   localparam int NODE_W        = 11;
   localparam int EDGE_W        = 10;
   localparam int ID_W          = 34;
   localparam int TET_W         = 5;
   localparam int TETS_PER_CUBE = 24;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = NODE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_NODES_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_Z    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_EDGE = 2'd3;

   localparam logic [TET_W-1:0] LAST_TET = TET_W'(TETS_PER_CUBE - 1);

   typedef logic [ID_W-1:0] node_id_type;

   // One tetrahedron: face slot and two corner slots of the cube
   typedef struct packed {
      logic [2:0] face;
      logic [2:0] corner_a;
      logic [2:0] corner_b;
   } tet_entry_type;

   localparam tet_entry_type TET_TABLE [TETS_PER_CUBE] = '{
      '{3'd0, 3'd0, 3'd1}, '{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd3, 3'd2}, '{3'd0, 3'd2, 3'd0},
      '{3'd1, 3'd1, 3'd5}, '{3'd1, 3'd5, 3'd7}, '{3'd1, 3'd7, 3'd3}, '{3'd1, 3'd3, 3'd1},
      '{3'd2, 3'd5, 3'd4}, '{3'd2, 3'd4, 3'd6}, '{3'd2, 3'd6, 3'd7}, '{3'd2, 3'd7, 3'd5},
      '{3'd3, 3'd4, 3'd0}, '{3'd3, 3'd0, 3'd2}, '{3'd3, 3'd2, 3'd6}, '{3'd3, 3'd6, 3'd4},
      '{3'd4, 3'd1, 3'd0}, '{3'd4, 3'd0, 3'd4}, '{3'd4, 3'd4, 3'd5}, '{3'd4, 3'd5, 3'd1},
      '{3'd5, 3'd2, 3'd3}, '{3'd5, 3'd3, 3'd7}, '{3'd5, 3'd7, 3'd6}, '{3'd5, 3'd6, 3'd2}
   };

endpackage

@@ hdl/cube_to_24_tet_connectivity_top.sv @@
// Channel  | Direction | Handshake             | Beat contents
// ---------+-----------+-----------------------+-------------------------------------------
// req_     | in        | req_valid / req_ready | cube_x, cube_y, cube_z block indices
// rsp_     | out       | rsp_valid / rsp_ready | tet_number, centre, face, two corners, flags
// csr_     | in        | csr_wr_en             | csr_index, csr_wdata (no read-back)
//
// An in-range cube gives 24 result beats, one per cycle while rsp_ready is high; the
// emitter takes a new cube only after its last beat. An out-of-range cube gives one beat.
// The single result port sets this rate. A request beat runs through three stages, the
// emitter and the output register. After reset and after every register write the block
// counts and id bases are rebuilt: a load state, the divider steps and 12 multiplier steps;
// req_ready stays low meanwhile. Reset is synchronous, active high. A rsp_ready stall holds
// the output and a full emitter; others fill only gaps. Nothing is dropped or repeated.
module cube_to_24_tet_connectivity_top
   import c2tet_pkg::*;
#(
   parameter int MAX_AXIS_NODES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CUBE_W-1:0]     req_cube_x,
   input  logic [CUBE_W-1:0]     req_cube_y,
   input  logic [CUBE_W-1:0]     req_cube_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TET_W-1:0]      rsp_tet_number,
   output logic [ID_W-1:0]       rsp_centre_node,
   output logic [ID_W-1:0]       rsp_face_node,
   output logic [ID_W-1:0]       rsp_corner_first,
   output logic [ID_W-1:0]       rsp_corner_second,
   output logic                  rsp_last_tet,
   output logic                  rsp_out_of_range,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Derived widths
   localparam int NODE_TOP = (1 << NODE_W) - 1;
   localparam int NODE_MAX = (MAX_AXIS_NODES > NODE_TOP) ? NODE_TOP : MAX_AXIS_NODES;
   localparam int CELL_W   = $clog2(NODE_MAX);
   localparam int BLK_W    = CELL_W;
   localparam int LN_W     = BLK_W + 1;
   localparam int SL_W     = 2 * LN_W;
   localparam int PR_W     = SL_W + LN_W;
   localparam int NUM_W    = ((CELL_W > EDGE_W) ? CELL_W : EDGE_W) + 1;
   localparam int DCNT_W   = $clog2(NUM_W);
   localparam int STEP_W   = 4;

   localparam logic [NODE_W-1:0] NODE_MAX_V = NODE_W'(NODE_MAX);
   localparam logic [NODE_W-1:0] NODE_MIN_V = NODE_W'(2);
   localparam logic [DCNT_W-1:0] DIV_LAST   = DCNT_W'(NUM_W - 1);

   // Setup sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   // Multiplier steps
   localparam logic [STEP_W-1:0] MS_SLICE  = 4'd0;
   localparam logic [STEP_W-1:0] MS_BXBY   = 4'd1;
   localparam logic [STEP_W-1:0] MS_LINEBY = 4'd2;
   localparam logic [STEP_W-1:0] MS_BXBY1  = 4'd3;
   localparam logic [STEP_W-1:0] MS_ZF     = 4'd4;
   localparam logic [STEP_W-1:0] MS_XFP    = 4'd5;
   localparam logic [STEP_W-1:0] MS_YFP    = 4'd6;
   localparam logic [STEP_W-1:0] MS_CP     = 4'd7;
   localparam logic [STEP_W-1:0] MS_CPST   = 4'd8;
   localparam logic [STEP_W-1:0] MS_XF     = 4'd9;
   localparam logic [STEP_W-1:0] MS_YF     = 4'd10;
   localparam logic [STEP_W-1:0] MS_CB     = 4'd11;

   // Configuration and setup state
   logic [NODE_W-1:0]  nodes_ff [3];
   logic [EDGE_W-1:0]  edge_ff;
   logic [1:0]         st_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic [STEP_W-1:0]  step_ff;

   logic [NUM_W-1:0]   div_num_ff [3];
   logic [EDGE_W-1:0]  div_rem_ff [3];
   logic [NUM_W-1:0]   div_num_in [3];
   logic [EDGE_W-1:0]  div_rem_in [3];
   logic [NUM_W-1:0]   div_load   [3];
   logic [EDGE_W-1:0]  edge_eff;

   logic [BLK_W-1:0]   blk_ff [3];
   logic [PR_W-1:0]    mul_ff;
   logic [SL_W-1:0]    slice_ff, bxby_ff, lineby_ff, bxby1_ff;
   node_id_type        zf_ff, xfp_ff, yfp_ff, cp_ff, xf_ff, yf_ff, cb_ff;

   logic [LN_W-1:0]    line, by1, bz1;
   logic [SL_W-1:0]    mul_a;
   logic [LN_W-1:0]    mul_b;
   logic               busy;

   // Item pipeline
   logic               s1_v_ff, s2_v_ff, s3_v_ff, e_v_ff, rsp_v_ff;
   logic               s1_rdy, s2_rdy, s3_rdy, e_rdy, out_free, e_emit, e_last;

   logic [CUBE_W-1:0]  s1_i_ff, s1_j_ff, s1_k_ff;
   logic               s1_oor_ff;
   logic               oor_in;

   logic [CUBE_W-1:0]        s2_i_ff;
   logic                     s2_oor_ff;
   logic [CUBE_W+LN_W-1:0]   jl_ff;
   logic [CUBE_W+BLK_W-1:0]  jb_ff;
   logic [CUBE_W+SL_W-1:0]   ks_ff, kbb_ff, klb_ff, kbb1_ff;

   logic               s3_oor_ff;
   node_id_type        c0_ff, cidx_ff, x3_ff, y4_ff;

   node_id_type        e_corner_ff [8];
   node_id_type        e_face_ff   [6];
   node_id_type        e_centre_ff;
   logic               e_oor_ff;
   logic [TET_W-1:0]   e_cnt_ff;
   tet_entry_type      tbl;

   logic [TET_W-1:0]   rsp_tet_ff;
   node_id_type        rsp_centre_ff, rsp_face_ff, rsp_ca_ff, rsp_cb_ff;
   logic               rsp_last_ff, rsp_oor_ff;

   // Divider lanes: clamp, ceiling numerator and one restoring step
   always_comb begin
      logic [NODE_W-1:0] clamped;
      logic [EDGE_W:0]   rem_sh;
      edge_eff = (edge_ff == '0) ? EDGE_W'(1) : edge_ff;
      for (int a = 0; a < 3; a++) begin
         if (nodes_ff[a] < NODE_MIN_V) begin
            clamped = NODE_MIN_V;
         end else if (nodes_ff[a] > NODE_MAX_V) begin
            clamped = NODE_MAX_V;
         end else begin
            clamped = nodes_ff[a];
         end
         div_load[a] = NUM_W'(CELL_W'(clamped - NODE_W'(1))) + NUM_W'(edge_eff)
                       - NUM_W'(1);
         rem_sh = {div_rem_ff[a], div_num_ff[a][NUM_W-1]};
         if (rem_sh >= {1'b0, edge_eff}) begin
            div_rem_in[a] = EDGE_W'(rem_sh - {1'b0, edge_eff});
            div_num_in[a] = {div_num_ff[a][NUM_W-2:0], 1'b1};
         end else begin
            div_rem_in[a] = EDGE_W'(rem_sh);
            div_num_in[a] = {div_num_ff[a][NUM_W-2:0], 1'b0};
         end
      end
   end

   // Multiplier operands per setup step
   always_comb begin
      line  = LN_W'(blk_ff[0]) + LN_W'(1);
      by1   = LN_W'(blk_ff[1]) + LN_W'(1);
      bz1   = LN_W'(blk_ff[2]) + LN_W'(1);
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         MS_SLICE:  begin mul_a = SL_W'(line);      mul_b = by1;                end
         MS_BXBY:   begin mul_a = SL_W'(blk_ff[0]); mul_b = LN_W'(blk_ff[1]);   end
         MS_LINEBY: begin mul_a = SL_W'(line);      mul_b = LN_W'(blk_ff[1]);   end
         MS_BXBY1:  begin mul_a = SL_W'(blk_ff[0]); mul_b = by1;                end
         MS_ZF:     begin mul_a = slice_ff;         mul_b = bz1;                end
         MS_XFP:    begin mul_a = bxby_ff;          mul_b = bz1;                end
         MS_YFP:    begin mul_a = lineby_ff;        mul_b = LN_W'(blk_ff[2]);   end
         MS_CP:     begin mul_a = bxby1_ff;         mul_b = LN_W'(blk_ff[2]);   end
         default:   begin mul_a = '0;               mul_b = '0;                 end
      endcase
   end

   // Registers and setup sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff[0] <= NODE_W'(2);
         nodes_ff[1] <= NODE_W'(2);
         nodes_ff[2] <= NODE_W'(2);
         edge_ff     <= EDGE_W'(1);
         st_ff       <= ST_LOAD;
         div_cnt_ff  <= '0;
         step_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NODES_X:    nodes_ff[0] <= csr_wdata;
            CSR_NODES_Y:    nodes_ff[1] <= csr_wdata;
            CSR_NODES_Z:    nodes_ff[2] <= csr_wdata;
            CSR_BLOCK_EDGE: edge_ff     <= csr_wdata[EDGE_W-1:0];
         endcase
         st_ff <= ST_LOAD;
      end else begin
         unique case (st_ff)
            ST_IDLE: st_ff <= ST_IDLE;
            ST_LOAD: begin
               div_cnt_ff <= '0;
               st_ff      <= ST_DIV;
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DIV_LAST) begin
                  step_ff <= MS_SLICE;
                  st_ff   <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == MS_CB) begin
                  st_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   // Setup datapath: divide, then build products and id bases
   always_ff @(posedge clock) begin
      if (st_ff == ST_LOAD) begin
         for (int a = 0; a < 3; a++) begin
            div_num_ff[a] <= div_load[a];
            div_rem_ff[a] <= '0;
         end
      end
      if (st_ff == ST_DIV) begin
         for (int a = 0; a < 3; a++) begin
            div_num_ff[a] <= div_num_in[a];
            div_rem_ff[a] <= div_rem_in[a];
            if (div_cnt_ff == DIV_LAST) begin
               blk_ff[a] <= BLK_W'(div_num_in[a]);
            end
         end
      end
      if (st_ff == ST_MUL) begin
         mul_ff <= mul_a * mul_b;
         // store the product of the step before; the last three steps add up id bases
         case (step_ff)
            MS_BXBY:   slice_ff  <= SL_W'(mul_ff);
            MS_LINEBY: bxby_ff   <= SL_W'(mul_ff);
            MS_BXBY1:  lineby_ff <= SL_W'(mul_ff);
            MS_ZF:     bxby1_ff  <= SL_W'(mul_ff);
            MS_XFP:    zf_ff     <= ID_W'(mul_ff);
            MS_YFP:    xfp_ff    <= ID_W'(mul_ff);
            MS_CP:     yfp_ff    <= ID_W'(mul_ff);
            MS_CPST:   cp_ff     <= ID_W'(mul_ff);
            MS_XF:     xf_ff     <= zf_ff + xfp_ff;
            MS_YF:     yf_ff     <= xf_ff + yfp_ff;
            MS_CB:     cb_ff     <= yf_ff + cp_ff;
            default:   cb_ff     <= cb_ff;
         endcase
      end
   end

   // Handshake chain: a stage advances when empty or when the next one takes it
   assign busy     = (st_ff != ST_IDLE);
   assign out_free = !rsp_v_ff || rsp_ready;
   assign e_emit   = e_v_ff && out_free;
   assign e_last   = e_oor_ff || (e_cnt_ff == LAST_TET);
   assign e_rdy    = !e_v_ff || (e_emit && e_last);
   assign s3_rdy   = !s3_v_ff || e_rdy;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign req_ready = s1_rdy && !busy;

   assign oor_in = (32'(req_cube_x) >= 32'(blk_ff[0])) ||
                   (32'(req_cube_y) >= 32'(blk_ff[1])) ||
                   (32'(req_cube_z) >= 32'(blk_ff[2]));

   // Valid bits and emit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         e_v_ff   <= 1'b0;
         e_cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid && !busy;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (e_rdy) begin
            e_v_ff   <= s3_v_ff;
            e_cnt_ff <= '0;
         end else if (e_emit) begin
            e_cnt_ff <= e_cnt_ff + TET_W'(1);
         end
         if (out_free) rsp_v_ff <= e_v_ff;
      end
   end

   // Stage 1: capture the beat and check the block range
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_i_ff   <= req_cube_x;
         s1_j_ff   <= req_cube_y;
         s1_k_ff   <= req_cube_z;
         s1_oor_ff <= oor_in;
      end
   end

   // Stage 2: row and slice products
   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_i_ff   <= s1_i_ff;
         s2_oor_ff <= s1_oor_ff;
         jl_ff     <= s1_j_ff * line;
         jb_ff     <= s1_j_ff * blk_ff[0];
         ks_ff     <= s1_k_ff * slice_ff;
         kbb_ff    <= s1_k_ff * bxby_ff;
         klb_ff    <= s1_k_ff * lineby_ff;
         kbb1_ff   <= s1_k_ff * bxby1_ff;
      end
   end

   // Stage 3: local offsets in each id range
   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_oor_ff <= s2_oor_ff;
         c0_ff     <= ID_W'(s2_i_ff) + ID_W'(jl_ff) + ID_W'(ks_ff);
         cidx_ff   <= ID_W'(s2_i_ff) + ID_W'(jb_ff) + ID_W'(kbb_ff);
         x3_ff     <= ID_W'(s2_i_ff) + ID_W'(jl_ff) + ID_W'(klb_ff);
         y4_ff     <= ID_W'(s2_i_ff) + ID_W'(jb_ff) + ID_W'(kbb1_ff);
      end
   end

   // Emitter stage: corner, face and centre ids for the whole cube
   always_ff @(posedge clock) begin
      if (e_rdy) begin
         for (int n = 0; n < 8; n++) begin
            e_corner_ff[n] <= c0_ff
                              + (n[2] ? ID_W'(slice_ff) : '0)
                              + (n[1] ? ID_W'(line) : '0)
                              + ID_W'(n[0]);
         end
         e_face_ff[0] <= zf_ff + cidx_ff;
         e_face_ff[1] <= xf_ff + x3_ff + ID_W'(1);
         e_face_ff[2] <= zf_ff + cidx_ff + ID_W'(bxby_ff);
         e_face_ff[3] <= xf_ff + x3_ff;
         e_face_ff[4] <= yf_ff + y4_ff;
         e_face_ff[5] <= yf_ff + y4_ff + ID_W'(blk_ff[0]);
         e_centre_ff  <= cb_ff + cidx_ff;
         e_oor_ff     <= s3_oor_ff;
      end
   end

   // Output register: one tetrahedron per beat
   assign tbl = TET_TABLE[e_cnt_ff];

   always_ff @(posedge clock) begin
      if (e_emit) begin
         rsp_last_ff <= e_last;
         rsp_oor_ff  <= e_oor_ff;
         if (e_oor_ff) begin
            rsp_tet_ff    <= '0;
            rsp_centre_ff <= '0;
            rsp_face_ff   <= '0;
            rsp_ca_ff     <= '0;
            rsp_cb_ff     <= '0;
         end else begin
            rsp_tet_ff    <= e_cnt_ff;
            rsp_centre_ff <= e_centre_ff;
            rsp_face_ff   <= e_face_ff[tbl.face];
            rsp_ca_ff     <= e_corner_ff[tbl.corner_a];
            rsp_cb_ff     <= e_corner_ff[tbl.corner_b];
         end
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_tet_number    = rsp_tet_ff;
   assign rsp_centre_node   = rsp_centre_ff;
   assign rsp_face_node     = rsp_face_ff;
   assign rsp_corner_first  = rsp_ca_ff;
   assign rsp_corner_second = rsp_cb_ff;
   assign rsp_last_tet      = rsp_last_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

   // Checks
   a_no_accept_in_setup: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("request taken while setup runs");

   a_oor_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_oor_ff) |-> (rsp_last_ff && (rsp_tet_ff == '0) &&
                                    (rsp_centre_ff == '0) && (rsp_face_ff == '0)))
      else $error("out-of-range beat not single or not cleared");

   a_tet_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_ready && !rsp_last_ff) |=>
         (rsp_v_ff && (rsp_tet_ff == TET_W'($past(rsp_tet_ff) + TET_W'(1)))))
      else $error("tetrahedron sequence broken");

   a_emitter_holds: assert property (@(posedge clock) disable iff (reset)
      (e_v_ff && !e_emit) |=> (e_v_ff && $stable(e_cnt_ff)))
      else $error("emitter moved while output stalled");

endmodule
